// ===== hw/rtl/tdl_pkg.sv =====
// shared types, constants and fixed-point helpers for the td(lambda) learner
`default_nettype none
package tdl_pkg;
   localparam int VectorLengthDefault = 64;
   localparam int IndexWidth = 6;
   localparam int DataWidth = 32;
   localparam int RateWidth = 17;
   localparam int QueueDepth = 4;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_LEARN   = 2'd1;
   localparam logic [1:0] OP_PREDICT = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [1:0] KIND_VALUE   = 2'd0;
   localparam logic [1:0] KIND_PREDICT = 2'd1;
   localparam logic [1:0] KIND_WEIGHT  = 2'd2;

   localparam logic [1:0] CSR_STEP_SIZE   = 2'd0;
   localparam logic [1:0] CSR_TRACE_DECAY = 2'd1;
   localparam logic [1:0] CSR_DISCOUNT    = 2'd2;

   localparam logic [RateWidth-1:0] STEP_SIZE_RESET   = 17'd6554;
   localparam logic [RateWidth-1:0] TRACE_DECAY_RESET = 17'd58982;
   localparam logic [RateWidth-1:0] DISCOUNT_RESET    = 17'd64881;

   typedef struct packed {
      logic [1:0]  op;
      logic [IndexWidth-1:0] index;
      logic signed [31:0] feature;
      logic signed [31:0] weight;
      logic signed [31:0] reward;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic signed [31:0] value;
   } rsp_type;

   // saturate a 64-bit value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   // floor shift of a 64-bit product by 16, then saturate
   function automatic logic signed [31:0] fix32(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] add32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) + 64'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) - 64'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] s,
                                                 input logic signed [63:0] p);
      logic signed [63:0] r;
      r = s + p;
      if (!s[63] && !p[63] && r[63]) r = 64'sh7fffffffffffffff;
      else if (s[63] && p[63] && !r[63]) r = 64'sh8000000000000000;
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tdl_req_if.sv =====
// request channel interface
`default_nettype none
interface tdl_req_if import tdl_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tdl_rsp_if.sv =====
// response channel interface
`default_nettype none
interface tdl_rsp_if import tdl_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tdl_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module tdl_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tdl_front.sv =====
// front end: takes request beats, flags out-of-range indexes, queues work
`default_nettype none
module tdl_front import tdl_pkg::*; #(
   parameter int VectorLength = VectorLengthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   tdl_req_if.sink   req,
   output logic      q_valid,
   output req_type   q_data,
   output logic      q_ok,
   input  wire logic q_pop
);
   localparam int PtrW = $clog2(QueueDepth);
   req_type          buf_ff [QueueDepth];
   logic             ok_ff [QueueDepth];
   logic [PtrW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [PtrW:0]    cnt_ff, cnt_in;
   logic             push, in_ok;

   assign req.ready = (cnt_ff != (PtrW+1)'(QueueDepth));
   assign push      = req.valid && req.ready;
   assign in_ok     = (32'(req.data.index) < 32'(VectorLength));
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = buf_ff[rp_ff];
   assign q_ok      = ok_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= req.data;
         ok_ff[wp_ff] <= in_ok;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrW+1)'(QueueDepth))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count not advanced");
endmodule
`default_nettype wire

// ===== hw/rtl/tdl_back.sv =====
// back end: sequencer that runs load, learn, predict and read on the vector memories
`default_nettype none
module tdl_back import tdl_pkg::*; #(
   parameter int VectorLength = VectorLengthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  req_type                   q_data,
   input  wire logic                 q_ok,
   output logic                      q_pop,
   input  wire logic [RateWidth-1:0] alpha,
   input  wire logic [RateWidth-1:0] lambda,
   input  wire logic [RateWidth-1:0] gamma,
   tdl_rsp_if.source                 rsp
);
   localparam int AW = (VectorLength > 1) ? $clog2(VectorLength) : 1;
   localparam int CW = $clog2(VectorLength + 1) + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ACC   = 4'd1;  // memory read latency for predict/read
   localparam logic [3:0] S_DOT   = 4'd2;  // dot products pass
   localparam logic [3:0] S_SCAL1 = 4'd3;
   localparam logic [3:0] S_SCAL2 = 4'd4;
   localparam logic [3:0] S_SCAL3 = 4'd5;
   localparam logic [3:0] S_SCAL4 = 4'd6;
   localparam logic [3:0] S_UPD   = 4'd7;  // trace and weight update pass
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_CLR   = 4'd9;  // clearing pass after reset

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] ra;
   // pipelined address and phase of update pass
   logic [1:0]  ph_ff, ph_in;
   logic [AW-1:0] pa_ff;

   // memories
   logic          w_we, e_we, c_we, n_we;
   logic [AW-1:0] w_wa, e_wa, c_wa, n_wa;
   logic [31:0]   w_wd, e_wd, c_wd, n_wd;
   logic [31:0]   w_rd, e_rd, c_rd, n_rd;

   tdl_ram #(.Width(32), .Depth(VectorLength)) u_w (.clock, .wr_en(w_we), .wr_addr(w_wa),
      .wr_data(w_wd), .rd_addr(ra), .rd_data(w_rd));
   tdl_ram #(.Width(32), .Depth(VectorLength)) u_e (.clock, .wr_en(e_we), .wr_addr(e_wa),
      .wr_data(e_wd), .rd_addr(ra), .rd_data(e_rd));
   tdl_ram #(.Width(32), .Depth(VectorLength)) u_c (.clock, .wr_en(c_we), .wr_addr(c_wa),
      .wr_data(c_wd), .rd_addr(ra), .rd_data(c_rd));
   tdl_ram #(.Width(32), .Depth(VectorLength)) u_n (.clock, .wr_en(n_we), .wr_addr(n_wa),
      .wr_data(n_wd), .rd_addr(ra), .rd_data(n_rd));

   logic signed [63:0] acc_ff, acc_in;      // predict accumulator
   logic signed [63:0] sv_ff, sv_in, svp_ff, svp_in, sep_ff, sep_in;
   logic signed [31:0] vold_ff, vold_in;
   logic signed [31:0] v_ff, v_in, vp_ff, vp_in, gl_ff, gl_in, agl_ff, agl_in;
   logic signed [31:0] c_ff, c_in, dv_ff, dv_in, a1_ff, a1_in, a2_ff, a2_in;
   logic signed [31:0] dl_ff, dl_in;
   logic signed [63:0] pp_ff, pp_in;        // registered product in update pass
   logic signed [31:0] t_ff, t_in;          // partial trace value
   logic signed [31:0] ne_ff, ne_in;        // new trace
   logic signed [31:0] wt_ff, wt_in;        // partial weight
   logic signed [31:0] phi_ff, phi_in, w_hold_ff, w_hold_in;
   logic               dv_ok_ff, dv_ok_in;  // read stage valid in dot and update passes
   logic [AW-1:0]      dpa_ff;
   logic               rv_ff, rv_in;
   rsp_type            rd_ff, rd_in;
   logic               sel_ok_ff;
   req_type            cur_ff;
   logic               out_free;

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   assign out_free  = !rv_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ph_in = ph_ff;
      q_pop = 1'b0;
      ra = cnt_ff[AW-1:0];
      w_we = 1'b0; e_we = 1'b0; c_we = 1'b0; n_we = 1'b0;
      w_wa = q_data.index[AW-1:0]; e_wa = w_wa; c_wa = w_wa; n_wa = w_wa;
      w_wd = q_data.weight; e_wd = '0; c_wd = q_data.feature; n_wd = q_data.feature;
      acc_in = acc_ff; sv_in = sv_ff; svp_in = svp_ff; sep_in = sep_ff;
      vold_in = vold_ff; v_in = v_ff; vp_in = vp_ff; gl_in = gl_ff; agl_in = agl_ff;
      c_in = c_ff; dv_in = dv_ff; a1_in = a1_ff; a2_in = a2_ff; dl_in = dl_ff;
      pp_in = pp_ff; t_in = t_ff; ne_in = ne_ff; wt_in = wt_ff;
      phi_in = phi_ff; w_hold_in = w_hold_ff;
      dv_ok_in = 1'b0;
      rv_in = rv_ff && !rsp.ready;
      rd_in = rd_ff;
      case (state_ff)
         S_CLR: begin
            w_we = 1'b1; e_we = 1'b1; c_we = 1'b1;
            w_wa = cnt_ff[AW-1:0]; e_wa = w_wa; c_wa = w_wa;
            w_wd = '0; c_wd = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(VectorLength - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            ra = q_data.index[AW-1:0];
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_data.op)
                  OP_LOAD: begin
                     w_we = q_ok; e_we = q_ok; c_we = q_ok;
                     vold_in = '0;
                  end
                  OP_LEARN: begin
                     n_we = q_ok;
                     if (q_data.last) begin
                        state_in = S_DOT;
                        cnt_in = '0;
                     end
                  end
                  default: state_in = S_ACC;
               endcase
            end
         end
         S_ACC: begin
            state_in = S_IDLE;
            if (cur_ff.op == OP_PREDICT) begin
               if (sel_ok_ff)
                  acc_in = sadd64(acc_ff, 64'(cur_ff.feature) * 64'($signed(w_rd)));
               if (cur_ff.last) begin
                  rv_in = 1'b1;
                  rd_in.kind = KIND_PREDICT;
                  rd_in.value = fix32(acc_in);
                  acc_in = '0;
               end
            end else begin
               rv_in = 1'b1;
               rd_in.kind = KIND_WEIGHT;
               rd_in.value = sel_ok_ff ? $signed(w_rd) : '0;
            end
         end
         S_DOT: begin
            // issue read at cnt, accumulate data read last cycle
            if (cnt_ff != CW'(VectorLength)) begin
               cnt_in = cnt_ff + 1'b1;
               dv_ok_in = 1'b1;
            end
            if (dv_ok_ff) begin
               sv_in  = sadd64(sv_ff,  64'($signed(c_rd)) * 64'($signed(w_rd)));
               svp_in = sadd64(svp_ff, 64'($signed(n_rd)) * 64'($signed(w_rd)));
               sep_in = sadd64(sep_ff, 64'($signed(c_rd)) * 64'($signed(e_rd)));
            end
            if (cnt_ff == CW'(VectorLength) && !dv_ok_ff) state_in = S_SCAL1;
         end
         S_SCAL1: begin
            v_in  = fix32(sv_ff);
            vp_in = fix32(svp_ff);
            gl_in = fix32(64'($signed({1'b0, gamma})) * 64'($signed({1'b0, lambda})));
            state_in = S_SCAL2;
         end
         S_SCAL2: begin
            dl_in = sub32(add32(cur_ff.reward,
                        fix32(64'($signed({1'b0, gamma})) * 64'(vp_ff))), v_ff);
            agl_in = fix32(64'($signed({1'b0, alpha})) * 64'(gl_ff));
            dv_in = sub32(v_ff, vold_ff);
            state_in = S_SCAL3;
         end
         S_SCAL3: begin
            c_in = fix32(64'(agl_ff) * 64'(fix32(sep_ff)));
            a2_in = fix32(64'($signed({1'b0, alpha})) * 64'(dv_ff));
            state_in = S_SCAL4;
         end
         S_SCAL4: begin
            a1_in = fix32(64'($signed({1'b0, alpha})) * 64'(add32(dl_ff, dv_ff)));
            state_in = S_UPD;
            cnt_in = '0;
            ph_in = '0;
         end
         S_UPD: begin
            // per element: read, then four steps each with one multiply
            ra = cnt_ff[AW-1:0];
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               2'd0: begin
                  if (dv_ok_ff) begin
                     phi_in = $signed(c_rd);
                     w_hold_in = $signed(w_rd);
                     pp_in = 64'(gl_ff) * 64'($signed(e_rd));
                  end else begin
                     ph_in = 2'd0;
                     dv_ok_in = 1'b1;
                  end
               end
               2'd1: begin
                  t_in = add32(fix32(pp_ff), phi_ff);
                  pp_in = 64'(c_ff) * 64'(phi_ff);
               end
               2'd2: begin
                  ne_in = sub32(t_ff, fix32(pp_ff));
                  pp_in = 64'(a1_ff) * 64'(ne_in);
               end
               default: begin
                  wt_in = add32(w_hold_ff, fix32(pp_ff));
                  e_we = 1'b1; e_wa = pa_ff; e_wd = ne_ff;
                  w_we = 1'b1; w_wa = pa_ff;
                  w_wd = sub32(wt_in, fix32(64'(a2_ff) * 64'(phi_ff)));
                  c_we = 1'b1; c_wa = pa_ff; c_wd = n_rd;
                  cnt_in = cnt_ff + 1'b1;
                  ph_in = 2'd0;
                  if (cnt_ff == CW'(VectorLength - 1)) state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;
               rd_in.kind = KIND_VALUE;
               rd_in.value = vp_ff;
               vold_in = vp_ff;
               sv_in = '0; svp_in = '0; sep_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff <= '0;
         ph_ff <= '0;
         rv_ff <= 1'b0;
         dv_ok_ff <= 1'b0;
         acc_ff <= '0;
         vold_ff <= '0;
         sv_ff <= '0; svp_ff <= '0; sep_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ph_ff <= ph_in;
         rv_ff <= rv_in;
         dv_ok_ff <= dv_ok_in;
         acc_ff <= acc_in;
         vold_ff <= vold_in;
         sv_ff <= sv_in; svp_ff <= svp_in; sep_ff <= sep_in;
      end
      if (q_pop) begin
         cur_ff <= q_data;
         sel_ok_ff <= q_ok;
      end
      pa_ff <= ra;
      dpa_ff <= ra;
      rd_ff <= rd_in;
      v_ff <= v_in; vp_ff <= vp_in; gl_ff <= gl_in; agl_ff <= agl_in;
      c_ff <= c_in; dv_ff <= dv_in; a1_ff <= a1_in; a2_ff <= a2_in; dl_ff <= dl_in;
      pp_ff <= pp_in; t_ff <= t_in; ne_ff <= ne_in; wt_ff <= wt_in;
      phi_ff <= phi_in; w_hold_ff <= w_hold_in;
   end

   // the update pass holds its read address steady for all four steps
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && ph_ff != 2'd0) |-> pa_ff == dpa_ff)
      else $error("update address moved");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff)
      else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("pop outside idle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> rv_ff && rd_ff.kind == KIND_VALUE)
      else $error("learn value not issued");
endmodule
`default_nettype wire

// ===== hw/rtl/true_online_td_lambda_update_unit.sv =====
// top level of the true online td(lambda) linear learner
//
// usage: request beats enter on req (op, index, feature, weight, reward,
// last); results leave on rsp (kind, value) with valid/ready handshakes.
// step size, trace decay and discount go through the csr port (index 0, 1, 2);
// the user must write them only while idle; the block does not enforce this.
// a four-entry queue decouples request acceptance from the sequencer.
// load and non-last learn beats are handled in the idle state; predict and
// read beats also pass through the read-wait state, whose result is registered.
// a last learn beat starts a dot pass, the scalar states SCAL1 to SCAL4 and
// an update pass (one read wait and four steps per element), then emits V';
// the passes walk the elements in turn via the single read port per memory.
// after reset a clearing pass zeroes weights, traces and features; queued
// beats wait until it ends.
// a stalled rsp holds its beat; the sequencer waits and the queue fills,
// then req.ready drops.
`default_nettype none
module true_online_td_lambda_update_unit import tdl_pkg::*; #(
   parameter int VECTOR_LENGTH = VectorLengthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tdl_req_if.sink                   req,
   tdl_rsp_if.source                 rsp,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [RateWidth-1:0] csr_write_data
);
   logic [RateWidth-1:0] alpha_ff, lambda_ff, gamma_ff;
   logic    q_valid, q_ok, q_pop;
   req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= STEP_SIZE_RESET;
         lambda_ff <= TRACE_DECAY_RESET;
         gamma_ff <= DISCOUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_SIZE:   alpha_ff <= csr_write_data;
            CSR_TRACE_DECAY: lambda_ff <= csr_write_data;
            CSR_DISCOUNT:    gamma_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   tdl_front #(.VectorLength(VECTOR_LENGTH)) u_front (
      .clock, .reset, .req, .q_valid, .q_data, .q_ok, .q_pop);

   tdl_back #(.VectorLength(VECTOR_LENGTH)) u_back (
      .clock, .reset, .q_valid, .q_data, .q_ok, .q_pop,
      .alpha(alpha_ff), .lambda(lambda_ff), .gamma(gamma_ff), .rsp);
endmodule
`default_nettype wire

// ===== tb/true_online_td_lambda_update_unit_test.sv =====
// testbench for the true online td(lambda) learner: table-driven and random beats against a predictor
`default_nettype none
module true_online_td_lambda_update_unit_test import tdl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VecLen = 64;
   localparam int RandItems = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_STEP_SIZE;
   logic [RateWidth-1:0] csr_write_data = '0;

   tdl_req_if req_ch ();
   tdl_rsp_if rsp_ch ();

   true_online_td_lambda_update_unit #(.VECTOR_LENGTH(VecLen)) u_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("true_online_td_lambda_update_unit test failed");
      $finish;
   end

   // learner state mirror
   logic signed [31:0] w_mem [VecLen];
   logic signed [31:0] e_mem [VecLen];
   logic signed [31:0] phi_mem [VecLen];
   logic signed [31:0] nphi_mem [VecLen];
   logic signed [31:0] v_old;
   logic signed [63:0] pred_acc;
   logic [RateWidth-1:0] alpha, lambda, gamma;

   rsp_type result_q [$];
   int mismatches = 0;
   bit quiet = 1'b0;
   bit nphi_written [VecLen];

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return clamp32(p >>> 16);
   endfunction

   function automatic logic signed [63:0] acc64(input logic signed [63:0] s,
                                               input logic signed [63:0] p);
      logic signed [64:0] r;
      r = 65'(s) + 65'(p);
      if (r > 65'sh0_7fffffffffffffff) return 64'sh7fffffffffffffff;
      if (r < -65'sh0_8000000000000000) return 64'sh8000000000000000;
      return r[63:0];
   endfunction

   function automatic logic signed [31:0] dot_w(input bit use_next, input bit with_traces);
      logic signed [63:0] s;
      logic signed [31:0] a, b;
      s = 0;
      for (int i = 0; i < VecLen; i++) begin
         a = use_next ? nphi_mem[i] : phi_mem[i];
         b = with_traces ? e_mem[i] : w_mem[i];
         s = acc64(s, 64'(a) * 64'(b));
      end
      return clamp32(s >>> 16);
   endfunction

   function automatic logic signed [31:0] td_update(input logic signed [31:0] r);
      logic signed [31:0] v, vp, delta, gl, agl, ephi, c, dv, a1, a2;
      v = dot_w(0, 0);
      vp = dot_w(1, 0);
      delta = clamp32(64'(clamp32(64'(r) + 64'(qmul(gamma, vp)))) - 64'(v));
      gl = qmul(gamma, lambda);
      agl = qmul(alpha, gl);
      ephi = dot_w(0, 1);
      c = qmul(agl, ephi);
      dv = clamp32(64'(v) - 64'(v_old));
      a1 = qmul(alpha, clamp32(64'(delta) + 64'(dv)));
      a2 = qmul(alpha, dv);
      for (int i = 0; i < VecLen; i++)
         e_mem[i] = clamp32(64'(clamp32(64'(qmul(gl, e_mem[i])) + 64'(phi_mem[i])))
                            - 64'(qmul(c, phi_mem[i])));
      for (int i = 0; i < VecLen; i++)
         w_mem[i] = clamp32(64'(clamp32(64'(w_mem[i]) + 64'(qmul(a1, e_mem[i]))))
                            - 64'(qmul(a2, phi_mem[i])));
      v_old = vp;
      for (int i = 0; i < VecLen; i++) phi_mem[i] = nphi_mem[i];
      return vp;
   endfunction

   // returns 1 when the beat produces a result
   function automatic bit predict_beat(input req_type b, output rsp_type o);
      o = '0;
      case (b.op)
         OP_LOAD: begin
            w_mem[b.index] = b.weight;
            phi_mem[b.index] = b.feature;
            e_mem[b.index] = 0;
            v_old = 0;
            return 0;
         end
         OP_LEARN: begin
            nphi_mem[b.index] = b.feature;
            nphi_written[b.index] = 1'b1;
            if (!b.last) return 0;
            o.kind = KIND_VALUE;
            o.value = td_update(b.reward);
            return 1;
         end
         OP_PREDICT: begin
            pred_acc = acc64(pred_acc, 64'(b.feature) * 64'(w_mem[b.index]));
            if (!b.last) return 0;
            o.kind = KIND_PREDICT;
            o.value = clamp32(pred_acc >>> 16);
            pred_acc = 0;
            return 1;
         end
         default: begin
            o.kind = KIND_WEIGHT;
            o.value = w_mem[b.index];
            return 1;
         end
      endcase
   endfunction

   // response side: random stalls, compare against oldest expectation
   initial begin
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         hold = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
         rsp_ch.ready <= (hold == 0);
         repeat (hold) @(posedge clock);
         if (hold != 0) rsp_ch.ready <= 1'b1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat kind %0d value %0d",
                                               rsp_ch.data.kind, rsp_ch.data.value);
            end else begin
               rsp_type exp_r;
               exp_r = result_q.pop_front();
               if (rsp_ch.data.kind !== exp_r.kind || rsp_ch.data.value !== exp_r.value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                              exp_r.kind, exp_r.value, rsp_ch.data.kind, rsp_ch.data.value);
               end
            end
         end
      end
   end

   task automatic send_beat(input req_type b, input bit idle_ok);
      rsp_type o;
      if (idle_ok && !quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_beat(b, o)) result_q.push_back(o);
   endtask

   task automatic drain;
      while (result_q.size() != 0) @(posedge clock);
      repeat (5 * VecLen + 40) @(posedge clock);
   endtask

   task automatic write_rate(input logic [1:0] idx, input logic [RateWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_STEP_SIZE: alpha = val;
         CSR_TRACE_DECAY: lambda = val;
         CSR_DISCOUNT: gamma = val;
         default: ;
      endcase
   endtask

   function automatic req_type mk(input logic [1:0] op, input logic [5:0] idx,
                                  input logic signed [31:0] f, input logic signed [31:0] w,
                                  input logic signed [31:0] r, input bit l);
      req_type b;
      b.op = op; b.index = idx; b.feature = f; b.weight = w; b.reward = r; b.last = l;
      return b;
   endfunction

   function automatic logic signed [31:0] rnd_val;
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'($urandom);
         default: return 32'($signed($urandom_range(0, 262143)) - 131072);
      endcase
   endfunction

   typedef struct {
      req_type b;
      bit has_exp;
      rsp_type exp_r;
   } stim_row;

   task automatic send_checked(input stim_row row);
      rsp_type o;
      send_beat(row.b, 1'b1);
      if (row.has_exp && result_q.size() != 0) begin
         o = result_q[$];
         if (o !== row.exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("table row expected kind %0d value %0d, predicted %0d",
                                            row.exp_r.kind, row.exp_r.value, o.value);
         end
      end
   endtask

   task automatic learn_vector(input bit random_len);
      int n;
      n = random_len ? $urandom_range(1, VecLen) : VecLen;
      for (int i = 0; i < VecLen; i++) begin
         if (i < n - 1 || !nphi_written[i]) ;
      end
      // always cover every index so no unwritten entry is read
      for (int i = 0; i < VecLen; i++)
         send_beat(mk(OP_LEARN, 6'(i), rnd_val(), 32'($urandom),
                      rnd_val(), i == VecLen - 1), 1'b1);
   endtask

   initial begin
      stim_row rows [$];
      req_type b;
      int results_seen;
      for (int i = 0; i < VecLen; i++) begin
         w_mem[i] = 0; e_mem[i] = 0; phi_mem[i] = 0; nphi_mem[i] = 0; nphi_written[i] = 0;
      end
      v_old = 0; pred_acc = 0;
      alpha = STEP_SIZE_RESET; lambda = TRACE_DECAY_RESET; gamma = DISCOUNT_RESET;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows.push_back('{mk(OP_READ, 6'd0, 0, 0, 0, 1'b0), 1, '{KIND_WEIGHT, 0}});
      rows.push_back('{mk(OP_LOAD, 6'd0, 32'sh7fffffff, 32'sh7fffffff, 0, 1'b1), 0, '0});
      rows.push_back('{mk(OP_LOAD, 6'd63, 32'sh80000000, 32'sh80000000, 0, 1'b0), 0, '0});
      rows.push_back('{mk(OP_READ, 6'd0, 0, 0, 0, 1'b1), 1, '{KIND_WEIGHT, 32'sh7fffffff}});
      rows.push_back('{mk(OP_READ, 6'd63, 0, 0, 0, 1'b0), 1, '{KIND_WEIGHT, 32'sh80000000}});
      rows.push_back('{mk(OP_PREDICT, 6'd0, 32'sh00010000, 0, 0, 1'b1), 1,
                       '{KIND_PREDICT, 32'sh7fffffff}});
      rows.push_back('{mk(OP_PREDICT, 6'd0, 32'sh7fffffff, 0, 0, 1'b0), 0, '0});
      rows.push_back('{mk(OP_PREDICT, 6'd63, 32'sh80000000, 0, 0, 1'b1), 0, '0});
      rows.push_back('{mk(OP_PREDICT, 6'd5, 32'shffffffff, 0, 0, 1'b1), 1,
                       '{KIND_PREDICT, 0}});
      rows.push_back('{mk(OP_LOAD, 6'd7, 32'sh00020000, 32'shfffe0000, 0, 1'b0), 0, '0});
      foreach (rows[k]) send_checked(rows[k]);
      for (int i = 0; i < VecLen; i++)
         send_beat(mk(OP_LEARN, 6'(i), i[0] ? 32'sh80000000 : 32'sh7fffffff, 0,
                      32'sh7fffffff, i == VecLen - 1), 1'b1);
      for (int i = 0; i < VecLen; i++)
         send_beat(mk(OP_LEARN, 6'(i), 32'(i) << 12, 0, 32'sh80000000,
                      i == VecLen - 1), 1'b1);
      req_ch.valid <= 1'b0;
      drain();

      // random phases across rate settings
      results_seen = 0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_rate(CSR_STEP_SIZE, 17'd65536); write_rate(CSR_TRACE_DECAY, 17'd65536);
                     write_rate(CSR_DISCOUNT, 17'd65536); end
            1: begin write_rate(CSR_STEP_SIZE, 17'd0); write_rate(CSR_TRACE_DECAY, 17'd0);
                     write_rate(CSR_DISCOUNT, 17'd0); end
            5: begin write_rate(CSR_STEP_SIZE, STEP_SIZE_RESET);
                     write_rate(CSR_TRACE_DECAY, TRACE_DECAY_RESET);
                     write_rate(CSR_DISCOUNT, DISCOUNT_RESET); end
            default: begin
               write_rate(CSR_STEP_SIZE, 17'($urandom_range(0, 131071)));
               write_rate(CSR_TRACE_DECAY, 17'($urandom_range(0, 131071)));
               write_rate(CSR_DISCOUNT, 17'($urandom_range(0, 131071)));
            end
         endcase
         if (ph == 5) quiet = 1'b1;
         for (int n = 0; n < RandItems / 6; ) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  learn_vector(1'b0);
                  n += VecLen;
               end
               2, 3, 4: begin
                  b = mk(OP_PREDICT, 6'($urandom), rnd_val(), 32'($urandom), 32'($urandom),
                         $urandom_range(0, 3) == 0);
                  send_beat(b, 1'b1); n++;
               end
               5, 6: begin
                  b = mk(OP_LOAD, 6'($urandom), rnd_val(), rnd_val(), 32'($urandom),
                         1'($urandom));
                  send_beat(b, 1'b1); n++;
               end
               default: begin
                  b = mk(OP_READ, 6'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                         1'($urandom));
                  send_beat(b, 1'b1); n++;
               end
            endcase
         end
         // close any open prediction so the accumulator starts clean
         send_beat(mk(OP_PREDICT, 6'd0, 0, 0, 0, 1'b1), 1'b1);
         req_ch.valid <= 1'b0;
         drain();
      end

      if (mismatches == 0 && result_q.size() == 0)
         $display("true_online_td_lambda_update_unit test passed");
      else
         $display("true_online_td_lambda_update_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire
